[rtl/ubfc_pkg.sv]
// ----------------------------------------------------------------------------
// ubfc_pkg
// Shared sizes, command codes and derived widths for the UART byte FIFO
// controller.
// ----------------------------------------------------------------------------
package ubfc_pkg;

  // Buffer depths.
  localparam int RX_DEPTH  = 64;
  localparam int TX_DEPTH  = 4096;
  // Most bytes that one host read may pop.
  localparam int MAX_BURST = 64;

  // Field widths of the transaction ports.
  localparam int CMD_W      = 3;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 16;
  localparam int RX_LEVEL_W = 7;
  localparam int TX_LEVEL_W = 13;
  localparam int CNT32_W    = 32;

  // Derived internal widths.
  localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
  localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);
  localparam int BURST_W  = $clog2(MAX_BURST + 1);
  // Wide enough for a TX fill level plus a full message length.
  localparam int TX_SUM_W = ((TX_CNT_W > LEN_W) ? TX_CNT_W : LEN_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LINE_BYTE  = 3'd0,
    CMD_TX_SLOT    = 3'd1,
    CMD_HOST_READ  = 3'd2,
    CMD_HOST_WRITE = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

endpackage

[rtl/ubfc_ram.sv]
// ----------------------------------------------------------------------------
// ubfc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ubfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/uart_byte_fifo_controller.sv]
// ----------------------------------------------------------------------------
// uart_byte_fifo_controller
// Receive and transmit byte FIFOs between a serial line and a host, with
// whole-message admission for host writes and burst pops for host reads.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge where start is high and busy is
// low, and every transaction produces its results one per cycle, each shown
// for exactly one cycle with result_valid high; the receiver cannot stall
// them, so it must take each result in the cycle it appears. Line bytes,
// transmit slots, host write bytes, clears and unknown commands give one
// result in the cycle after the transaction and never raise busy, so one of
// them can be issued every cycle. A host read that pops n bytes (n is the
// smallest of the requested length, the receive fill level and MAX_BURST)
// gives one result per pop, in consecutive cycles; busy is high while pops
// are still being issued, since each pop reads the receive RAM one entry
// per cycle through its single read port. The status ports
// (overflow_flag, status, rx_available, rx_level, tx_level and the three
// counters) are live and, during a result cycle, show the state after the
// action of that result. data_out reads 0 whenever data_valid is low.
// No clearing pass is run after reset: the byte stores are never read
// before they are written.
// ----------------------------------------------------------------------------
module uart_byte_fifo_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ubfc_pkg::CMD_W-1:0]    command,
  input  logic [ubfc_pkg::BYTE_W-1:0]   data_byte,
  input  logic [ubfc_pkg::LEN_W-1:0]    length,
  input  logic                          first_of_message,
  output logic                          result_valid,
  output logic [ubfc_pkg::BYTE_W-1:0]   data_out,
  output logic                          data_valid,
  output logic                          last,
  output logic                          accepted,
  output logic                          overflow_flag,
  output logic                          status,
  output logic                          rx_available,
  output logic [ubfc_pkg::RX_LEVEL_W-1:0] rx_level,
  output logic [ubfc_pkg::TX_LEVEL_W-1:0] tx_level,
  output logic [ubfc_pkg::CNT32_W-1:0]  rx_drop_count,
  output logic [ubfc_pkg::CNT32_W-1:0]  rx_total,
  output logic [ubfc_pkg::CNT32_W-1:0]  tx_total
);

  import ubfc_pkg::*;

  // Idle takes any transaction; burst keeps popping for a host read.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } state_t;

  state_t state, state_next;

  // FIFO pointers and levels.
  logic [RX_PTR_W-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [RX_CNT_W-1:0] rx_fill, rx_fill_next;
  logic [TX_PTR_W-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [TX_CNT_W-1:0] tx_fill, tx_fill_next;
  logic                rx_overflow, rx_overflow_next;
  logic                link_status, link_status_next;

  // Counters.
  logic [CNT32_W-1:0] drop_count, drop_count_next;
  logic [CNT32_W-1:0] rx_bytes_total, rx_bytes_total_next;
  logic [CNT32_W-1:0] tx_bytes_total, tx_bytes_total_next;

  // Host message tracking.
  logic [LEN_W-1:0] msg_remaining, msg_remaining_next;
  logic             msg_admitted, msg_admitted_next;

  // Pops still to issue in a host read burst.
  logic [BURST_W-1:0] burst_left, burst_left_next;

  // Result register. The popped byte itself comes straight from the RAM
  // read register, selected by res_from_tx.
  logic res_valid, res_valid_next;
  logic res_dv, res_dv_next;
  logic res_last, res_last_next;
  logic res_acc, res_acc_next;
  logic res_from_tx, res_from_tx_next;

  // RAM ports.
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  // Wrapped pointer increments.
  logic [RX_PTR_W-1:0] rx_head_inc, rx_tail_inc;
  logic [TX_PTR_W-1:0] tx_head_inc, tx_tail_inc;

  // Host read and host write helpers.
  logic [LEN_W-1:0]    rx_fill_wide;
  logic [LEN_W-1:0]    read_req;
  logic [BURST_W-1:0]  read_cnt;
  logic [TX_SUM_W-1:0] tx_sum;
  logic                msg_fits;
  logic                wr_admit;
  logic                wr_push;
  logic [LEN_W-1:0]    wr_remaining;

  assign rx_head_inc = (rx_head == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
  assign rx_tail_inc = (rx_tail == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
  assign tx_head_inc = (tx_head == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
  assign tx_tail_inc = (tx_tail == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;

  // A host read pops min(length, fill) bytes, never more than one burst.
  assign rx_fill_wide = LEN_W'(rx_fill);
  assign read_req     = (length < rx_fill_wide) ? length : rx_fill_wide;
  assign read_cnt     = (read_req > LEN_W'(MAX_BURST)) ? BURST_W'(MAX_BURST)
                                                      : BURST_W'(read_req);

  // A new message is admitted whole only if all of it fits in TX now.
  assign tx_sum   = TX_SUM_W'(tx_fill) + TX_SUM_W'(length);
  assign msg_fits = (length != '0) && (tx_sum <= TX_SUM_W'(TX_DEPTH));

  // Host write byte bookkeeping. A first byte starts a new message and
  // abandons any earlier one; a later byte counts down the current message;
  // a stray byte with no message in progress changes nothing.
  always_comb begin
    wr_admit     = msg_admitted;
    wr_push      = 1'b0;
    wr_remaining = msg_remaining;
    if (first_of_message) begin
      wr_admit     = msg_fits;
      wr_push      = msg_fits;
      wr_remaining = (length != '0) ? length - 1'b1 : '0;
    end else if (msg_remaining != '0) begin
      wr_push      = msg_admitted;
      wr_remaining = msg_remaining - 1'b1;
    end
  end

  always_comb begin
    state_next          = state;
    rx_head_next        = rx_head;
    rx_tail_next        = rx_tail;
    rx_fill_next        = rx_fill;
    tx_head_next        = tx_head;
    tx_tail_next        = tx_tail;
    tx_fill_next        = tx_fill;
    rx_overflow_next    = rx_overflow;
    link_status_next    = link_status;
    drop_count_next     = drop_count;
    rx_bytes_total_next = rx_bytes_total;
    tx_bytes_total_next = tx_bytes_total;
    msg_remaining_next  = msg_remaining;
    msg_admitted_next   = msg_admitted;
    burst_left_next     = burst_left;
    res_valid_next      = 1'b0;
    res_dv_next         = 1'b0;
    res_last_next       = 1'b1;
    res_acc_next        = 1'b0;
    res_from_tx_next    = res_from_tx;
    rx_we               = 1'b0;
    rx_re               = 1'b0;
    tx_we               = 1'b0;
    tx_re               = 1'b0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          res_valid_next = 1'b1;
          case (command)
            CMD_LINE_BYTE: begin
              if (rx_fill < RX_CNT_W'(RX_DEPTH)) begin
                rx_we               = 1'b1;
                rx_head_next        = rx_head_inc;
                rx_fill_next        = rx_fill + 1'b1;
                rx_bytes_total_next = rx_bytes_total + 1'b1;
                link_status_next    = 1'b1;
                res_acc_next        = 1'b1;
              end else begin
                rx_overflow_next = 1'b1;
                drop_count_next  = drop_count + 1'b1;
              end
            end
            CMD_TX_SLOT: begin
              if (tx_fill != '0) begin
                tx_re            = 1'b1;
                tx_tail_next     = tx_tail_inc;
                tx_fill_next     = tx_fill - 1'b1;
                res_dv_next      = 1'b1;
                res_acc_next     = 1'b1;
                res_from_tx_next = 1'b1;
                if (tx_fill == TX_CNT_W'(1)) begin
                  link_status_next = 1'b0;
                end
              end
            end
            CMD_HOST_READ: begin
              if (read_cnt != '0) begin
                rx_re            = 1'b1;
                rx_tail_next     = rx_tail_inc;
                rx_fill_next     = rx_fill - 1'b1;
                res_dv_next      = 1'b1;
                res_acc_next     = 1'b1;
                res_from_tx_next = 1'b0;
                res_last_next    = (read_cnt == BURST_W'(1));
                burst_left_next  = read_cnt - 1'b1;
                if (read_cnt != BURST_W'(1)) begin
                  state_next = ST_BURST;
                end
              end
            end
            CMD_HOST_WRITE: begin
              if (first_of_message && msg_fits) begin
                tx_bytes_total_next = tx_bytes_total + CNT32_W'(length);
              end
              if (wr_push && (tx_fill < TX_CNT_W'(TX_DEPTH))) begin
                tx_we        = 1'b1;
                tx_head_next = tx_head_inc;
                tx_fill_next = tx_fill + 1'b1;
                res_acc_next = 1'b1;
              end
              msg_remaining_next = wr_remaining;
              msg_admitted_next  = (wr_remaining == '0) ? 1'b0 : wr_admit;
            end
            CMD_CLEAR: begin
              rx_head_next       = '0;
              rx_tail_next       = '0;
              rx_fill_next       = '0;
              tx_head_next       = '0;
              tx_tail_next       = '0;
              tx_fill_next       = '0;
              rx_overflow_next   = 1'b0;
              msg_remaining_next = '0;
              msg_admitted_next  = 1'b0;
              res_acc_next       = 1'b1;
            end
            default: begin
              // Unknown command: one empty result, no state change.
            end
          endcase
        end
      end
      ST_BURST: begin
        // The result of the previous pop is shown while this one reads.
        rx_re            = 1'b1;
        rx_tail_next     = rx_tail_inc;
        rx_fill_next     = rx_fill - 1'b1;
        res_valid_next   = 1'b1;
        res_dv_next      = 1'b1;
        res_acc_next     = 1'b1;
        res_from_tx_next = 1'b0;
        res_last_next    = (burst_left == BURST_W'(1));
        burst_left_next  = burst_left - 1'b1;
        if (burst_left == BURST_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rx_head        <= '0;
      rx_tail        <= '0;
      rx_fill        <= '0;
      tx_head        <= '0;
      tx_tail        <= '0;
      tx_fill        <= '0;
      rx_overflow    <= 1'b0;
      link_status    <= 1'b0;
      drop_count     <= '0;
      rx_bytes_total <= '0;
      tx_bytes_total <= '0;
      msg_remaining  <= '0;
      msg_admitted   <= 1'b0;
      burst_left     <= '0;
      res_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      rx_head        <= rx_head_next;
      rx_tail        <= rx_tail_next;
      rx_fill        <= rx_fill_next;
      tx_head        <= tx_head_next;
      tx_tail        <= tx_tail_next;
      tx_fill        <= tx_fill_next;
      rx_overflow    <= rx_overflow_next;
      link_status    <= link_status_next;
      drop_count     <= drop_count_next;
      rx_bytes_total <= rx_bytes_total_next;
      tx_bytes_total <= tx_bytes_total_next;
      msg_remaining  <= msg_remaining_next;
      msg_admitted   <= msg_admitted_next;
      burst_left     <= burst_left_next;
      res_valid      <= res_valid_next;
    end
  end

  // Result payload needs no reset; it is only looked at under res_valid.
  always_ff @(posedge clk) begin
    res_dv      <= res_dv_next;
    res_last    <= res_last_next;
    res_acc     <= res_acc_next;
    res_from_tx <= res_from_tx_next;
  end

  // Receive store: written by line bytes, read by host read pops.
  ubfc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RX_DEPTH)
  ) u_rx_ram (
    .clk  (clk),
    .we   (rx_we),
    .waddr(rx_head),
    .wdata(data_byte),
    .re   (rx_re),
    .raddr(rx_tail),
    .rdata(rx_rdata)
  );

  // Transmit store: written by admitted host bytes, read by transmit slots.
  ubfc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(TX_DEPTH)
  ) u_tx_ram (
    .clk  (clk),
    .we   (tx_we),
    .waddr(tx_head),
    .wdata(data_byte),
    .re   (tx_re),
    .raddr(tx_tail),
    .rdata(tx_rdata)
  );

  assign busy          = (state == ST_BURST);
  assign result_valid  = res_valid;
  assign data_valid    = res_dv;
  assign last          = res_last;
  assign accepted      = res_acc;
  assign data_out      = !res_dv ? '0 : (res_from_tx ? tx_rdata : rx_rdata);
  assign overflow_flag = rx_overflow;
  assign status        = link_status;
  assign rx_available  = (rx_fill != '0);
  assign rx_level      = RX_LEVEL_W'(rx_fill);
  assign tx_level      = TX_LEVEL_W'(tx_fill);
  assign rx_drop_count = drop_count;
  assign rx_total      = rx_bytes_total;
  assign tx_total      = tx_bytes_total;

endmodule

[rtl/ubfc_checker.sv]
// ----------------------------------------------------------------------------
// ubfc_checker
// Port-level checks of the UART byte FIFO controller, bound to the top level.
// ----------------------------------------------------------------------------
module ubfc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            result_valid,
  input logic                            data_valid,
  input logic                            last,
  input logic                            accepted,
  input logic                            rx_available,
  input logic [ubfc_pkg::RX_LEVEL_W-1:0] rx_level
);

  import ubfc_pkg::*;

  // Every transaction taken shows its first result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> result_valid)
    else $error("no result after a transaction was taken");

  // A result that is not the last of its burst leaves the block busy.
  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("burst result not last while block is idle");

  // A popped byte is always an accepted action.
  a_pop_accepted: assert property (@(posedge clk) disable iff (rst)
    (result_valid && data_valid) |-> accepted)
    else $error("byte popped without accepted");

  // Receive level and availability agree and the level stays in range.
  a_rx_level: assert property (@(posedge clk) disable iff (rst)
    (rx_available == (rx_level != '0)) && (rx_level <= RX_LEVEL_W'(RX_DEPTH)))
    else $error("receive level and availability disagree");

endmodule

bind uart_byte_fifo_controller ubfc_checker u_ubfc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .result_valid(result_valid),
  .data_valid  (data_valid),
  .last        (last),
  .accepted    (accepted),
  .rx_available(rx_available),
  .rx_level    (rx_level)
);

[sim/ubfc_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ubfc_result_checker
// Watches the transaction and result ports of the UART byte FIFO controller,
// keeps its own copy of both byte FIFOs and the counters, and compares every
// result strobe, field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module ubfc_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [ubfc_pkg::CMD_W-1:0]      command,
  input  logic [ubfc_pkg::BYTE_W-1:0]     data_byte,
  input  logic [ubfc_pkg::LEN_W-1:0]      length,
  input  logic                            first_of_message,
  input  logic                            result_valid,
  input  logic [ubfc_pkg::BYTE_W-1:0]     data_out,
  input  logic                            data_valid,
  input  logic                            last,
  input  logic                            accepted,
  input  logic                            overflow_flag,
  input  logic                            status,
  input  logic                            rx_available,
  input  logic [ubfc_pkg::RX_LEVEL_W-1:0] rx_level,
  input  logic [ubfc_pkg::TX_LEVEL_W-1:0] tx_level,
  input  logic [ubfc_pkg::CNT32_W-1:0]    rx_drop_count,
  input  logic [ubfc_pkg::CNT32_W-1:0]    rx_total,
  input  logic [ubfc_pkg::CNT32_W-1:0]    tx_total,
  output int                              mismatches,
  output int                              results_waiting
);
  import ubfc_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0]     data_out;
    logic                  data_valid;
    logic                  last;
    logic                  accepted;
    logic                  overflow_flag;
    logic                  status;
    logic                  rx_available;
    logic [RX_LEVEL_W-1:0] rx_level;
    logic [TX_LEVEL_W-1:0] tx_level;
    logic [CNT32_W-1:0]    rx_drop_count;
    logic [CNT32_W-1:0]    rx_total;
    logic [CNT32_W-1:0]    tx_total;
  } fifo_result_t;

  // Shadow copy of the block state. Both depths are powers of two, so the
  // pointers wrap by overflowing.
  logic [BYTE_W-1:0]     rx_mem [RX_DEPTH];
  logic [RX_PTR_W-1:0]   rx_wr;
  logic [RX_PTR_W-1:0]   rx_rd;
  logic [RX_LEVEL_W-1:0] rx_fill;
  logic                  rx_ovf;
  logic [BYTE_W-1:0]     tx_mem [TX_DEPTH];
  logic [TX_PTR_W-1:0]   tx_wr;
  logic [TX_PTR_W-1:0]   tx_rd;
  logic [TX_LEVEL_W-1:0] tx_fill;
  logic                  link_receiving;
  logic [CNT32_W-1:0]    drop_cnt;
  logic [CNT32_W-1:0]    rx_byte_sum;
  logic [CNT32_W-1:0]    tx_len_sum;
  logic [LEN_W-1:0]      msg_left;
  logic                  msg_admitted;

  fifo_result_t pending_results[$];
  int           result_no;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: result %0d: %s", $time, result_no, msg);
  endtask

  // Queues one predicted result carrying the state as it stands now.
  function automatic void queue_result(input logic [BYTE_W-1:0] b, input logic v,
                                       input logic l, input logic a);
    fifo_result_t r;
    r.data_out      = b;
    r.data_valid    = v;
    r.last          = l;
    r.accepted      = a;
    r.overflow_flag = rx_ovf;
    r.status        = link_receiving;
    r.rx_available  = (rx_fill != 0);
    r.rx_level      = rx_fill;
    r.tx_level      = tx_fill;
    r.rx_drop_count = drop_cnt;
    r.rx_total      = rx_byte_sum;
    r.tx_total      = tx_len_sum;
    pending_results.push_back(r);
  endfunction

  function automatic logic push_tx_byte(input logic [BYTE_W-1:0] b);
    if (tx_fill >= TX_DEPTH) return 1'b0;
    tx_mem[tx_wr] = b;
    tx_wr   = tx_wr + 1'b1;
    tx_fill = tx_fill + 1'b1;
    return 1'b1;
  endfunction

  function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                        input logic [BYTE_W-1:0] b,
                                        input logic [LEN_W-1:0] len,
                                        input logic first);
    int unsigned       n;
    int unsigned       fill_after;
    logic              acc;
    logic [BYTE_W-1:0] popped;
    case (cmd)
      CMD_LINE_BYTE: begin
        if (rx_fill >= RX_DEPTH) begin
          rx_ovf   = 1'b1;
          drop_cnt = drop_cnt + 1'b1;
          queue_result('0, 1'b0, 1'b1, 1'b0);
        end else begin
          rx_mem[rx_wr]  = b;
          rx_wr          = rx_wr + 1'b1;
          rx_fill        = rx_fill + 1'b1;
          rx_byte_sum    = rx_byte_sum + 1'b1;
          link_receiving = 1'b1;
          queue_result('0, 1'b0, 1'b1, 1'b1);
        end
      end
      CMD_TX_SLOT: begin
        if (tx_fill != 0) begin
          popped  = tx_mem[tx_rd];
          tx_rd   = tx_rd + 1'b1;
          tx_fill = tx_fill - 1'b1;
          if (tx_fill == 0) link_receiving = 1'b0;
          queue_result(popped, 1'b1, 1'b1, 1'b1);
        end else begin
          queue_result('0, 1'b0, 1'b1, 1'b0);
        end
      end
      CMD_HOST_READ: begin
        n = (len < rx_fill) ? len : rx_fill;
        if (n > MAX_BURST) n = MAX_BURST;
        if (n == 0) begin
          queue_result('0, 1'b0, 1'b1, 1'b0);
        end else begin
          for (int k = 0; k < n; k++) begin
            popped  = rx_mem[rx_rd];
            rx_rd   = rx_rd + 1'b1;
            rx_fill = rx_fill - 1'b1;
            queue_result(popped, 1'b1, (k + 1 == n), 1'b1);
          end
        end
      end
      CMD_HOST_WRITE: begin
        acc = 1'b0;
        if (first) begin
          fill_after = tx_fill + len;
          if (len != 0 && fill_after <= TX_DEPTH) begin
            msg_admitted = 1'b1;
            tx_len_sum   = tx_len_sum + len;
          end else begin
            msg_admitted = 1'b0;
          end
          msg_left = (len != 0) ? len - 1'b1 : '0;
          if (msg_admitted) acc = push_tx_byte(b);
        end else if (msg_left != 0) begin
          msg_left = msg_left - 1'b1;
          if (msg_admitted) acc = push_tx_byte(b);
        end
        if (msg_left == 0) msg_admitted = 1'b0;
        queue_result('0, 1'b0, 1'b1, acc);
      end
      CMD_CLEAR: begin
        rx_wr        = '0;
        rx_rd        = '0;
        rx_fill      = '0;
        rx_ovf       = 1'b0;
        tx_wr        = '0;
        tx_rd        = '0;
        tx_fill      = '0;
        msg_left     = '0;
        msg_admitted = 1'b0;
        queue_result('0, 1'b0, 1'b1, 1'b1);
      end
      default: begin
        queue_result('0, 1'b0, 1'b1, 1'b0);
      end
    endcase
  endfunction

  // Results are checked before the transaction of the same edge is predicted,
  // so a result can never match an expectation raised at its own edge.
  always @(posedge clk) begin
    fifo_result_t want;
    if (rst) begin
      rx_wr          = '0;
      rx_rd          = '0;
      rx_fill        = '0;
      rx_ovf         = 1'b0;
      tx_wr          = '0;
      tx_rd          = '0;
      tx_fill        = '0;
      link_receiving = 1'b0;
      drop_cnt       = '0;
      rx_byte_sum    = '0;
      tx_len_sum     = '0;
      msg_left       = '0;
      msg_admitted   = 1'b0;
      result_no      = 0;
      pending_results.delete();
    end else begin
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result strobe with no result expected");
        end else begin
          want = pending_results.pop_front();
          if (data_out !== want.data_out)
            report_mismatch($sformatf("data_out 0x%0h, expected 0x%0h", data_out,
                                      want.data_out));
          if (data_valid !== want.data_valid)
            report_mismatch($sformatf("data_valid %b, expected %b", data_valid,
                                      want.data_valid));
          if (last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", last, want.last));
          if (accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, expected %b", accepted,
                                      want.accepted));
          if (overflow_flag !== want.overflow_flag)
            report_mismatch($sformatf("overflow_flag %b, expected %b", overflow_flag,
                                      want.overflow_flag));
          if (status !== want.status)
            report_mismatch($sformatf("status %b, expected %b", status, want.status));
          if (rx_available !== want.rx_available)
            report_mismatch($sformatf("rx_available %b, expected %b", rx_available,
                                      want.rx_available));
          if (rx_level !== want.rx_level)
            report_mismatch($sformatf("rx_level %0d, expected %0d", rx_level,
                                      want.rx_level));
          if (tx_level !== want.tx_level)
            report_mismatch($sformatf("tx_level %0d, expected %0d", tx_level,
                                      want.tx_level));
          if (rx_drop_count !== want.rx_drop_count)
            report_mismatch($sformatf("rx_drop_count %0d, expected %0d", rx_drop_count,
                                      want.rx_drop_count));
          if (rx_total !== want.rx_total)
            report_mismatch($sformatf("rx_total %0d, expected %0d", rx_total,
                                      want.rx_total));
          if (tx_total !== want.tx_total)
            report_mismatch($sformatf("tx_total %0d, expected %0d", tx_total,
                                      want.tx_total));
        end
        result_no++;
      end
      if (start && !busy) begin
        apply_command(command, data_byte, length, first_of_message);
      end
    end
    results_waiting <= pending_results.size();
  end

endmodule

[sim/tb_uart_byte_fifo_controller.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_byte_fifo_controller
// Drives command transactions into the UART byte FIFO controller: a directed
// pass over the corner cases, one pass that overfills the receive FIFO,
// then random traffic in several sender idling phases. The result checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_uart_byte_fifo_controller;
  import ubfc_pkg::*;

  // Command codes the block does not define; they must be ignored.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Cycles without any transaction or result before the run is declared hung.
  // The longest legal quiet stretch is a sender gap, which is longest in the
  // phase at 48 percent idling.
  localparam int STALL_LIMIT  = 2000;
  // Every transaction answers in the cycle after it is taken, so the drain
  // after the last expected result is enough to catch a stray one.
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 45;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      command;
  logic [BYTE_W-1:0]     data_byte;
  logic [LEN_W-1:0]      length;
  logic                  first_of_message;
  logic                  result_valid;
  logic [BYTE_W-1:0]     data_out;
  logic                  data_valid;
  logic                  last;
  logic                  accepted;
  logic                  overflow_flag;
  logic                  status;
  logic                  rx_available;
  logic [RX_LEVEL_W-1:0] rx_level;
  logic [TX_LEVEL_W-1:0] tx_level;
  logic [CNT32_W-1:0]    rx_drop_count;
  logic [CNT32_W-1:0]    rx_total;
  logic [CNT32_W-1:0]    tx_total;

  int mismatch_count;
  int results_waiting;
  int stall_cycles;
  int idle_pct;
  int items_done;

  uart_byte_fifo_controller u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .data_byte        (data_byte),
    .length           (length),
    .first_of_message (first_of_message),
    .result_valid     (result_valid),
    .data_out         (data_out),
    .data_valid       (data_valid),
    .last             (last),
    .accepted         (accepted),
    .overflow_flag    (overflow_flag),
    .status           (status),
    .rx_available     (rx_available),
    .rx_level         (rx_level),
    .tx_level         (tx_level),
    .rx_drop_count    (rx_drop_count),
    .rx_total         (rx_total),
    .tx_total         (tx_total)
  );

  ubfc_result_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .data_byte        (data_byte),
    .length           (length),
    .first_of_message (first_of_message),
    .result_valid     (result_valid),
    .data_out         (data_out),
    .data_valid       (data_valid),
    .last             (last),
    .accepted         (accepted),
    .overflow_flag    (overflow_flag),
    .status           (status),
    .rx_available     (rx_available),
    .rx_level         (rx_level),
    .tx_level         (tx_level),
    .rx_drop_count    (rx_drop_count),
    .rx_total         (rx_total),
    .tx_total         (tx_total),
    .mismatches       (mismatch_count),
    .results_waiting  (results_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The watchdog restarts its count on every transaction and every result.
  // Reset counts as activity so the reset cycles never eat into the limit.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("uart_byte_fifo_controller verification failed");
        $finish;
      end
    end
  end

  // Issues one transaction and returns at the edge where it is taken. An
  // optional run of idle cycles comes first; start stays high across
  // back-to-back transactions so it is never dropped and raised in one step.
  // While busy is high the transaction simply waits with start held.
  task automatic issue_txn(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                           input logic [LEN_W-1:0] len, input logic first);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    command          <= cmd;
    data_byte        <= b;
    length           <= len;
    first_of_message <= first;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd <= CMD_CLEAR) items_done++;
  endtask

  // Corner cases: empty buffers, ignored commands, field extremes, every
  // flavor of host message that gets dropped, and the TX admission edge.
  task automatic run_directed();
    // Reads and transmit slots with nothing to pop, and a stray host byte.
    issue_txn(CMD_HOST_READ, 8'h5A, 16'd5, 1'b1);
    issue_txn(CMD_TX_SLOT, 8'hFF, LEN_MAX, 1'b1);
    issue_txn(CMD_HOST_WRITE, 8'h3C, 16'd9, 1'b0);
    for (int k = CMD_UNKNOWN_LO; k <= CMD_UNKNOWN_HI; k++) begin
      issue_txn(CMD_W'(k), 8'hFF, LEN_MAX, 1'b1);
    end
    // Three line bytes, then a zero-length read and a read for far more
    // than the FIFO holds.
    issue_txn(CMD_LINE_BYTE, 8'h00, 16'h0000, 1'b0);
    issue_txn(CMD_LINE_BYTE, 8'hFF, LEN_MAX, 1'b1);
    issue_txn(CMD_LINE_BYTE, 8'hA5, 16'h8001, 1'b0);
    issue_txn(CMD_HOST_READ, 8'h00, 16'd0, 1'b0);
    issue_txn(CMD_HOST_READ, 8'hFF, LEN_MAX, 1'b0);
    // A zero-length message, then a byte that is stray after it.
    issue_txn(CMD_HOST_WRITE, 8'h11, 16'd0, 1'b1);
    issue_txn(CMD_HOST_WRITE, 8'h12, 16'd7, 1'b0);
    // A message far too long: its first and later bytes are all dropped.
    issue_txn(CMD_HOST_WRITE, 8'h21, LEN_MAX, 1'b1);
    issue_txn(CMD_HOST_WRITE, 8'h22, 16'd0, 1'b0);
    // A message cut short by a new first byte, which starts over.
    issue_txn(CMD_HOST_WRITE, 8'h31, 16'd3, 1'b1);
    issue_txn(CMD_HOST_WRITE, 8'h32, LEN_MAX, 1'b0);
    issue_txn(CMD_HOST_WRITE, 8'h41, 16'd2, 1'b1);
    issue_txn(CMD_HOST_WRITE, 8'h42, 16'd0, 1'b0);
    // Drain TX: all four bytes, with no slot left to find it empty, so status
    // drops back to idle on the fourth pop.
    repeat (4) issue_txn(CMD_TX_SLOT, 8'h00, 16'd0, 1'b0);
    // Admission edge: a full-depth message fits an empty FIFO, the same
    // length one byte later does not, one byte shorter does.
    issue_txn(CMD_HOST_WRITE, 8'h51, LEN_W'(TX_DEPTH), 1'b1);
    issue_txn(CMD_HOST_WRITE, 8'h52, LEN_W'(TX_DEPTH), 1'b1);
    issue_txn(CMD_HOST_WRITE, 8'h53, LEN_W'(TX_DEPTH - 1), 1'b1);
    issue_txn(CMD_CLEAR, 8'hC3, LEN_MAX, 1'b1);
  endtask

  // Fills RX past its depth to force overflow drops, then empties it with
  // one maximum burst read.
  task automatic run_full_buffers();
    issue_txn(CMD_CLEAR, 8'h00, 16'd0, 1'b0);
    repeat (RX_DEPTH + 2) begin
      issue_txn(CMD_LINE_BYTE, BYTE_W'($urandom_range(255)),
                LEN_W'($urandom_range(65535)), 1'($urandom_range(1)));
    end
    issue_txn(CMD_HOST_READ, 8'h00, LEN_MAX, 1'b0);
    issue_txn(CMD_LINE_BYTE, BYTE_W'($urandom_range(255)), 16'd0, 1'b0);
    issue_txn(CMD_CLEAR, 8'h00, 16'd0, 1'b0);
  endtask

  // Random traffic built from short sequences: line byte bursts, reads,
  // whole host messages (some cut short, oversized or empty), transmit slot
  // bursts, and a little noise from clears, stray bytes and unknown codes.
  task automatic run_random(input int goal);
    int               stop_at;
    int               pick;
    int               count;
    int               rest;
    logic [LEN_W-1:0] len;
    stop_at = items_done + goal;
    while (items_done < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        count = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        repeat (count) begin
          issue_txn(CMD_LINE_BYTE, BYTE_W'($urandom_range(255)),
                    LEN_W'($urandom_range(65535)), 1'($urandom_range(1)));
        end
      end else if (pick < 45) begin
        case ($urandom_range(5))
          0:       len = '0;
          1:       len = LEN_W'($urandom_range(65535));
          default: len = LEN_W'($urandom_range(1, 20));
        endcase
        issue_txn(CMD_HOST_READ, BYTE_W'($urandom_range(255)), len,
                  1'($urandom_range(1)));
      end else if (pick < 70) begin
        case ($urandom_range(9))
          0:       len = '0;
          1:       len = LEN_W'($urandom_range(4097, 65535));
          2:       len = LEN_W'($urandom_range(9, 40));
          default: len = LEN_W'($urandom_range(1, 8));
        endcase
        if (len == 0 || len > 40) rest = $urandom_range(3);
        else rest = len - 1;
        // Now and then the message is abandoned part way through.
        if ($urandom_range(5) == 0) rest = $urandom_range(rest);
        issue_txn(CMD_HOST_WRITE, BYTE_W'($urandom_range(255)), len, 1'b1);
        repeat (rest) begin
          issue_txn(CMD_HOST_WRITE, BYTE_W'($urandom_range(255)),
                    LEN_W'($urandom_range(65535)), 1'b0);
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 10)) begin
          issue_txn(CMD_TX_SLOT, BYTE_W'($urandom_range(255)),
                    LEN_W'($urandom_range(65535)), 1'($urandom_range(1)));
        end
      end else if (pick < 90) begin
        issue_txn(CMD_CLEAR, BYTE_W'($urandom_range(255)),
                  LEN_W'($urandom_range(65535)), 1'($urandom_range(1)));
      end else if (pick < 95) begin
        issue_txn(CMD_HOST_WRITE, BYTE_W'($urandom_range(255)),
                  LEN_W'($urandom_range(65535)), 1'b0);
      end else begin
        issue_txn(CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI)),
                  BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(65535)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int idle_plan [4];
    idle_plan        = '{0, 48, 0, 24};
    idle_pct         = 0;
    items_done       = 0;
    rst              <= 1'b1;
    start            <= 1'b0;
    command          <= CMD_LINE_BYTE;
    data_byte        <= '0;
    length           <= '0;
    first_of_message <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    run_full_buffers();
    // The receiver cannot hold off results, so the phases differ only in
    // how often the sender sits idle.
    foreach (idle_plan[p]) begin
      idle_pct = idle_plan[p];
      run_random(PHASE_ITEMS);
    end
    start <= 1'b0;

    // The checker count is registered, so wait for the next edge before
    // looking at it; the watchdog bounds this wait if results never come.
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("uart_byte_fifo_controller verification clean");
    end else begin
      $display("uart_byte_fifo_controller verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ubfc_pkg.sv
rtl/ubfc_ram.sv
rtl/uart_byte_fifo_controller.sv
rtl/ubfc_checker.sv
sim/ubfc_result_checker.sv
sim/tb_uart_byte_fifo_controller.sv
